[design/iidl_pkg.sv]
// ----------------------------------------------------------------------------
// iidl_pkg: shared types and codes for the indexed insert/delete list
// Item layouts for both channels, operation and status codes, and the
// command that the list controller broadcasts to the row of cells.
// ----------------------------------------------------------------------------
package iidl_pkg;

  // Field widths fixed by the channel layout
  localparam int OP_BITS     = 3;
  localparam int VALUE_BITS  = 32;
  localparam int POS_BITS    = 4;
  localparam int STATUS_BITS = 2;
  localparam int COUNT_BITS  = 5;

  // Operation codes
  localparam logic [OP_BITS-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_BITS-1:0] OP_POP    = 3'd1;
  localparam logic [OP_BITS-1:0] OP_INSERT = 3'd2;
  localparam logic [OP_BITS-1:0] OP_ERASE  = 3'd3;
  localparam logic [OP_BITS-1:0] OP_READ   = 3'd4;

  // Status codes
  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_POS   = 2'd3;

  // Request item
  typedef struct packed {
    logic        [OP_BITS-1:0]    op;
    logic signed [VALUE_BITS-1:0] value;
    logic        [POS_BITS-1:0]   position;
  } iidl_req_t;

  // Response item
  typedef struct packed {
    logic        [STATUS_BITS-1:0] status;
    logic        [COUNT_BITS-1:0]  count;
    logic                          is_empty;
    logic                          is_full;
    logic signed [VALUE_BITS-1:0]  read_value;
  } iidl_rsp_t;

  // Cell command: open a gap at the target (ins) or close it (del)
  typedef struct packed {
    logic ins;
    logic del;
  } iidl_cmd_t;

endpackage

[design/iidl_cell.sv]
// ----------------------------------------------------------------------------
// iidl_cell: one entry of the list
// Holds one word. On an insert it loads the new word when it sits at the
// target or takes its lower neighbor's word when it sits above; on an erase
// it takes its upper neighbor's word from the target upward.
// ----------------------------------------------------------------------------
module iidl_cell #(
  parameter int WORD_BITS = 32,
  parameter int IDX_W     = 9,
  parameter int IDX       = 0
) (
  input  logic                 clk,
  input  iidl_pkg::iidl_cmd_t  cmd,
  input  logic [IDX_W-1:0]     target,
  input  logic [WORD_BITS-1:0] value,
  input  logic [WORD_BITS-1:0] left_word,
  input  logic [WORD_BITS-1:0] right_word,
  output logic [WORD_BITS-1:0] word
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  // Entry storage, no reset: contents are defined once written
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (MY_IDX == target) begin
        word <= value;
      end else if (MY_IDX > target) begin
        word <= left_word;
      end
    end else if (cmd.del) begin
      if (MY_IDX >= target) begin
        word <= right_word;
      end
    end
  end

endmodule

[design/indexed_insert_delete_list.sv]
// ----------------------------------------------------------------------------
// indexed_insert_delete_list: fixed-capacity ordered list of signed words
// Push, pop, insert, erase and read on a list of up to DEPTH entries.
// ----------------------------------------------------------------------------
// The list takes one item per clock cycle while it is not stalled and returns
// its response from a register in the cycle after the item is accepted. Every
// entry lives in its own cell of a row; an insert or erase shifts the cells
// from the position upward by one place together, so no operation stalls the
// list. A new item is accepted while the response register is empty or being
// taken in the same cycle. Entries are stored as WORD_BITS bits and read back
// sign-extended; positions are 4 bits wide, so only the first sixteen entries
// can be addressed by insert, erase and read.
module indexed_insert_delete_list #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  iidl_pkg::iidl_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output iidl_pkg::iidl_rsp_t rsp
);

  localparam int LEN_W = $clog2(DEPTH + 1);
  localparam int CMP_W = LEN_W + iidl_pkg::POS_BITS;
  localparam int RD_N  = (DEPTH < (2 ** iidl_pkg::POS_BITS)) ? DEPTH
                                                            : (2 ** iidl_pkg::POS_BITS);
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

  logic [LEN_W-1:0]       length;
  logic [LEN_W-1:0]       length_next;
  logic                   accept;
  logic [CMP_W-1:0]       len_c;
  logic [CMP_W-1:0]       pos_c;
  logic [CMP_W-1:0]       target;
  logic                   full;
  logic                   empty;
  logic [iidl_pkg::STATUS_BITS-1:0] status_next;
  iidl_pkg::iidl_cmd_t    cmd;
  logic signed [63:0]     val64;
  logic [WORD_BITS-1:0]   val_word;
  logic [WORD_BITS-1:0]   words [DEPTH];
  logic signed [WORD_BITS-1:0] sel_word;
  logic signed [63:0]     rd64;
  logic [iidl_pkg::VALUE_BITS-1:0] rd_next;
  logic [LEN_W+iidl_pkg::COUNT_BITS-1:0] len_wide;
  iidl_pkg::iidl_rsp_t    rsp_next;

  // Handshake: the response register parts the two sides
  assign req_stall = rsp_valid & rsp_stall;
  assign accept    = req_valid & ~req_stall;

  // Operand preparation
  assign len_c    = CMP_W'(length);
  assign pos_c    = CMP_W'(req.position);
  assign full     = (len_c >= DEPTH_C);
  assign empty    = (length == '0);
  assign val64    = 64'(req.value);
  assign val_word = val64[WORD_BITS-1:0];

  // Checks, list update and cell command
  always_comb begin
    status_next = iidl_pkg::ST_OK;
    length_next = length;
    cmd         = '0;
    target      = pos_c;
    unique case (req.op)
      iidl_pkg::OP_PUSH: begin
        target = len_c;
        if (full) begin
          status_next = iidl_pkg::ST_FULL;
        end else begin
          cmd.ins     = 1'b1;
          length_next = length + 1'b1;
        end
      end
      iidl_pkg::OP_POP: begin
        if (empty) begin
          status_next = iidl_pkg::ST_EMPTY;
        end else begin
          length_next = length - 1'b1;
        end
      end
      iidl_pkg::OP_INSERT: begin
        if (full) begin
          status_next = iidl_pkg::ST_FULL;
        end else if (pos_c > len_c) begin
          status_next = iidl_pkg::ST_POS;
        end else begin
          cmd.ins     = 1'b1;
          length_next = length + 1'b1;
        end
      end
      iidl_pkg::OP_ERASE: begin
        if (empty) begin
          status_next = iidl_pkg::ST_EMPTY;
        end else if (pos_c >= len_c) begin
          status_next = iidl_pkg::ST_POS;
        end else begin
          cmd.del     = 1'b1;
          length_next = length - 1'b1;
        end
      end
      iidl_pkg::OP_READ: begin
        if (empty) begin
          status_next = iidl_pkg::ST_EMPTY;
        end else if (pos_c >= len_c) begin
          status_next = iidl_pkg::ST_POS;
        end
      end
      default: begin
      end
    endcase
  end

  // Row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    iidl_pkg::iidl_cmd_t cell_cmd;
    assign cell_cmd = accept ? cmd : '0;

    if (i == 0) begin : g_first
      iidl_cell #(.WORD_BITS(WORD_BITS), .IDX_W(CMP_W), .IDX(i)) u_cell (
        .clk        (clk),
        .cmd        (cell_cmd),
        .target     (target),
        .value      (val_word),
        .left_word  (val_word),
        .right_word (words[(i + 1 < DEPTH) ? i + 1 : i]),
        .word       (words[i])
      );
    end else begin : g_rest
      iidl_cell #(.WORD_BITS(WORD_BITS), .IDX_W(CMP_W), .IDX(i)) u_cell (
        .clk        (clk),
        .cmd        (cell_cmd),
        .target     (target),
        .value      (val_word),
        .left_word  (words[i - 1]),
        .right_word (words[(i + 1 < DEPTH) ? i + 1 : i]),
        .word       (words[i])
      );
    end
  end

  // Read select over the addressable cells
  always_comb begin
    sel_word = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (req.position == iidl_pkg::POS_BITS'(i)) begin
        sel_word = words[i];
      end
    end
  end

  assign rd64    = 64'(sel_word);
  assign rd_next = (req.op == iidl_pkg::OP_READ && status_next == iidl_pkg::ST_OK)
                   ? rd64[iidl_pkg::VALUE_BITS-1:0] : '0;

  // Response item
  assign len_wide = (LEN_W + iidl_pkg::COUNT_BITS)'(length_next);
  always_comb begin
    rsp_next.status     = status_next;
    rsp_next.count      = len_wide[iidl_pkg::COUNT_BITS-1:0];
    rsp_next.is_empty   = (length_next == '0);
    rsp_next.is_full    = (CMP_W'(length_next) == DEPTH_C);
    rsp_next.read_value = rd_next;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      length    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        length <= length_next;
      end
      rsp_valid <= accept | (rsp_valid & rsp_stall);
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  // Assertions
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(length) <= DEPTH_C)
    else $error("list length above capacity");

  a_flags_match: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.is_empty == (length == '0))
                  && (rsp.is_full == (CMP_W'(length) == DEPTH_C)))
    else $error("response flags disagree with list length");

  a_reject_hold: assert property (@(posedge clk) disable iff (rst)
    accept && status_next != iidl_pkg::ST_OK |=> $stable(length))
    else $error("rejected item changed the list length");

  a_push_grow: assert property (@(posedge clk) disable iff (rst)
    accept && req.op == iidl_pkg::OP_PUSH && status_next == iidl_pkg::ST_OK
    |=> length == $past(length) + 1'b1)
    else $error("push did not grow the list");

endmodule

[verif/indexed_insert_delete_list_tb.sv]
// ----------------------------------------------------------------------------
// indexed_insert_delete_list_tb: self-checking bench for the ordered list
// A queue-fed driver sends list operations with random gaps. A monitor takes
// the responses under random stall and compares each one, field by field,
// with the response that a behavioral copy of the list predicts.
// ----------------------------------------------------------------------------
module indexed_insert_delete_list_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = 16;
  localparam int WORD_BITS  = 32;
  localparam int NUM_ITEMS  = 1000;
  localparam int MAX_REPORT = 10;

  // Stimulus flavors for the random part
  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIX   = 2;
  localparam int MODE_NOISE = 3;

  // Op codes with no operation behind them
  localparam logic [iidl_pkg::OP_BITS-1:0] OP_SPARE5 = 3'd5;
  localparam logic [iidl_pkg::OP_BITS-1:0] OP_SPARE6 = 3'd6;
  localparam logic [iidl_pkg::OP_BITS-1:0] OP_SPARE7 = 3'd7;

  // Behavioral copy of the list contents and size
  typedef struct packed {
    logic [DEPTH-1:0][iidl_pkg::VALUE_BITS-1:0] entries;
    logic [iidl_pkg::COUNT_BITS-1:0]            len;
  } list_state_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_stall;
  iidl_pkg::iidl_req_t req       = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  iidl_pkg::iidl_rsp_t rsp;

  iidl_pkg::iidl_req_t pending_items[$];
  iidl_pkg::iidl_rsp_t expected_rsps[$];
  list_state_t list_shadow;     // tracks accepted items
  list_state_t gen_shadow;      // tracks items as they are generated

  int items_sent     = 0;
  int rsps_seen      = 0;
  int mismatches     = 0;
  int quiet_after    = 0;
  int req_gap        = 0;
  int stall_gap      = 0;
  int status_tally[4];
  int full_seen      = 0;

  indexed_insert_delete_list #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #4 clk = ~clk;

  // Apply one operation to a list copy and return the response it gives
  function automatic iidl_pkg::iidl_rsp_t apply_list_op(inout list_state_t st,
                                                         input iidl_pkg::iidl_req_t item);
    iidl_pkg::iidl_rsp_t r;
    int i;
    r = '0;
    r.status = iidl_pkg::ST_OK;
    case (item.op)
      iidl_pkg::OP_PUSH: begin
        if (st.len >= DEPTH) begin
          r.status = iidl_pkg::ST_FULL;
        end else begin
          st.entries[st.len] = item.value;
          st.len = st.len + 1'b1;
        end
      end
      iidl_pkg::OP_POP: begin
        if (st.len == 0) r.status = iidl_pkg::ST_EMPTY;
        else st.len = st.len - 1'b1;
      end
      iidl_pkg::OP_INSERT: begin
        if (st.len >= DEPTH) begin
          r.status = iidl_pkg::ST_FULL;
        end else if (item.position > st.len) begin
          r.status = iidl_pkg::ST_POS;
        end else begin
          for (i = int'(st.len); i > int'(item.position); i--)
            st.entries[i] = st.entries[i-1];
          st.entries[item.position] = item.value;
          st.len = st.len + 1'b1;
        end
      end
      iidl_pkg::OP_ERASE: begin
        if (st.len == 0) begin
          r.status = iidl_pkg::ST_EMPTY;
        end else if (item.position >= st.len) begin
          r.status = iidl_pkg::ST_POS;
        end else begin
          for (i = int'(item.position); i + 1 < int'(st.len); i++)
            st.entries[i] = st.entries[i+1];
          st.len = st.len - 1'b1;
        end
      end
      iidl_pkg::OP_READ: begin
        if (st.len == 0) r.status = iidl_pkg::ST_EMPTY;
        else if (item.position >= st.len) r.status = iidl_pkg::ST_POS;
        else r.read_value = st.entries[item.position];
      end
      default: ;  // unused codes leave the list alone
    endcase
    r.count    = st.len;
    r.is_empty = (st.len == 0);
    r.is_full  = (st.len == DEPTH);
    return r;
  endfunction

  // Queue one item and track the list size it leads to
  task automatic queue_item(input logic        [iidl_pkg::OP_BITS-1:0]    op,
                            input logic signed [iidl_pkg::VALUE_BITS-1:0] v,
                            input logic        [iidl_pkg::POS_BITS-1:0]   p);
    iidl_pkg::iidl_req_t item;
    iidl_pkg::iidl_rsp_t unused;
    item.op       = op;
    item.value    = v;
    item.position = p;
    unused = apply_list_op(gen_shadow, item);
    pending_items.push_back(item);
  endtask

  // Random word, with the extremes now and then
  function automatic logic signed [iidl_pkg::VALUE_BITS-1:0] pick_word();
    logic signed [iidl_pkg::VALUE_BITS-1:0] w;
    w = $urandom;
    case ($urandom_range(0, 15))
      0: w = 32'sh7fffffff;
      1: w = 32'sh80000000;
      2: w = '0;
      3: w = '1;
      default: ;
    endcase
    return w;
  endfunction

  // Request driver: predicts on acceptance, then moves to the next item or a gap
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req_gap   <= 0;
    end else begin
      if (req_valid && !req_stall) begin
        expected_rsps.push_back(apply_list_op(list_shadow, req));
        items_sent <= items_sent + 1;
      end
      if (!req_valid || !req_stall) begin
        if (req_gap > 0) begin
          req_valid <= 1'b0;
          req_gap   <= req_gap - 1;
        end else if (pending_items.size() > 0 && items_sent < quiet_after &&
                     $urandom_range(0, 7) == 0) begin
          req_valid <= 1'b0;
          req_gap   <= $urandom_range(0, 3);
        end else if (pending_items.size() > 0) begin
          req       <= pending_items.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Response stall in random bursts
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_gap <= 0;
    end else if (stall_gap > 0) begin
      rsp_stall <= 1'b1;
      stall_gap <= stall_gap - 1;
    end else if (rsps_seen < quiet_after && $urandom_range(0, 7) == 0) begin
      rsp_stall <= 1'b1;
      stall_gap <= $urandom_range(0, 3);
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // Response monitor
  always @(posedge clk) begin
    iidl_pkg::iidl_rsp_t exp_rsp;
    if (!rst && rsp_valid && !rsp_stall) begin
      rsps_seen <= rsps_seen + 1;
      if (expected_rsps.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < MAX_REPORT)
          $display("unexpected response %h with nothing pending", rsp);
      end else begin
        exp_rsp = expected_rsps.pop_front();
        status_tally[rsp.status] <= status_tally[rsp.status] + 1;
        if (rsp.is_full) full_seen <= full_seen + 1;
        if (rsp.status !== exp_rsp.status || rsp.count !== exp_rsp.count ||
            rsp.is_empty !== exp_rsp.is_empty || rsp.is_full !== exp_rsp.is_full ||
            rsp.read_value !== exp_rsp.read_value) begin
          mismatches <= mismatches + 1;
          if (mismatches < MAX_REPORT)
            $display({"mismatch at response %0d: expected status=%0d count=%0d ",
                      "empty=%b full=%b rd=%h, got status=%0d count=%0d ",
                      "empty=%b full=%b rd=%h"},
                     rsps_seen, exp_rsp.status, exp_rsp.count, exp_rsp.is_empty,
                     exp_rsp.is_full, exp_rsp.read_value, rsp.status, rsp.count,
                     rsp.is_empty, rsp.is_full, rsp.read_value);
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int mode;
    int run_len;
    int pick;
    int len;
    logic [iidl_pkg::OP_BITS-1:0]  op;
    logic [iidl_pkg::POS_BITS-1:0] p;

    list_shadow = '0;
    gen_shadow  = '0;
    for (int s = 0; s < 4; s++) status_tally[s] = 0;

    // Directed: empty-list rejects, edges of positions and words, unused codes
    queue_item(iidl_pkg::OP_READ,   0, 0);
    queue_item(iidl_pkg::OP_POP,    0, 0);
    queue_item(iidl_pkg::OP_ERASE,  0, 0);
    queue_item(iidl_pkg::OP_INSERT, 5, 1);           // past the size of an empty list
    queue_item(iidl_pkg::OP_INSERT, 32'sh7fffffff, 0);
    queue_item(iidl_pkg::OP_PUSH,   32'sh80000000, 0);
    queue_item(iidl_pkg::OP_INSERT, 0, 2);           // at the tail
    queue_item(iidl_pkg::OP_INSERT, -1, 1);          // in the middle
    queue_item(iidl_pkg::OP_READ,   0, 0);
    queue_item(iidl_pkg::OP_READ,   0, 3);
    queue_item(iidl_pkg::OP_READ,   0, 4);           // one past the end
    queue_item(iidl_pkg::OP_READ,   0, 15);
    queue_item(iidl_pkg::OP_ERASE,  0, 4);
    queue_item(iidl_pkg::OP_ERASE,  0, 1);
    queue_item(iidl_pkg::OP_ERASE,  0, 0);
    queue_item(OP_SPARE5,           32'sh12345678, 15);
    queue_item(OP_SPARE6,           0, 0);
    queue_item(OP_SPARE7,           -1, 7);
    queue_item(iidl_pkg::OP_READ,   0, 1);
    queue_item(iidl_pkg::OP_POP,    0, 0);
    queue_item(iidl_pkg::OP_POP,    0, 0);

    // Random: runs that fill, drain, mix, or send anything at all
    while (pending_items.size() < NUM_ITEMS) begin
      mode    = $urandom_range(MODE_FILL, MODE_NOISE);
      run_len = $urandom_range(10, 40);
      repeat (run_len) begin
        len  = int'(gen_shadow.len);
        pick = $urandom_range(0, 99);
        case (mode)
          MODE_FILL:  op = (pick < 45) ? iidl_pkg::OP_PUSH :
                           (pick < 85) ? iidl_pkg::OP_INSERT :
                           (pick < 95) ? iidl_pkg::OP_READ : iidl_pkg::OP_ERASE;
          MODE_DRAIN: op = (pick < 40) ? iidl_pkg::OP_POP :
                           (pick < 80) ? iidl_pkg::OP_ERASE :
                           (pick < 92) ? iidl_pkg::OP_READ : iidl_pkg::OP_PUSH;
          MODE_MIX:   op = (pick < 40) ? iidl_pkg::OP_READ :
                           (pick < 55) ? iidl_pkg::OP_PUSH :
                           (pick < 70) ? iidl_pkg::OP_INSERT :
                           (pick < 85) ? iidl_pkg::OP_ERASE : iidl_pkg::OP_POP;
          default:    op = iidl_pkg::OP_BITS'($urandom_range(0, 7));
        endcase
        if (mode == MODE_NOISE || $urandom_range(0, 9) == 0)
          p = iidl_pkg::POS_BITS'($urandom_range(0, 15));
        else if (op == iidl_pkg::OP_INSERT)
          p = iidl_pkg::POS_BITS'($urandom_range(0, (len > 15) ? 15 : len));
        else
          p = (len == 0) ? '0 : iidl_pkg::POS_BITS'($urandom_range(0, len - 1));
        queue_item(op, pick_word(), p);
      end
    end
    quiet_after = pending_items.size() * 85 / 100;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Drain, then let the pipeline run on idle before the summary
    do @(negedge clk);
    while (pending_items.size() > 0 || req_valid || expected_rsps.size() > 0);
    repeat (10) @(negedge clk);

    $display("Ran %0d list operations: %0d ok, %0d full rejects, %0d empty rejects,",
             items_sent, status_tally[iidl_pkg::ST_OK], status_tally[iidl_pkg::ST_FULL],
             status_tally[iidl_pkg::ST_EMPTY]);
    $display("%0d bad positions; list reported full in %0d responses; %0d mismatches",
             status_tally[iidl_pkg::ST_POS], full_seen, mismatches);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("timeout with %0d responses outstanding", expected_rsps.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[filelist.f]
design/iidl_pkg.sv
design/iidl_cell.sv
design/indexed_insert_delete_list.sv
verif/indexed_insert_delete_list_tb.sv
